[hdl/bdec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdec_pkg: shared definitions for the binary to decimal ASCII converter
// Widths, constants and types used by the converter, the queue and the
// digit emitter.
// ----------------------------------------------------------------------------
package bdec_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int IN_BITS     = 32;
    localparam int CHAR_BITS   = 6;

    // Bits that actually take part in the conversion.
    localparam int CONV_BITS   = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
    localparam int BCD_BITS    = 4 * MAX_DIGITS;
    localparam int DCNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int POS_W       = $clog2(MAX_DIGITS);
    localparam int SCNT_W      = $clog2(CONV_BITS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0] ASCII_NINE = CHAR_BITS'(57);

    typedef logic [BCD_BITS-1:0] t_bcd;
    typedef logic [DCNT_W-1:0]   t_dcnt;
    typedef logic [POS_W-1:0]    t_pos;

    // One converted value waiting to be emitted.
    typedef struct packed {
        t_bcd  bcd;
        t_dcnt count;
    } t_entry;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

[hdl/bdec_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdec_ifs: stream channels of the converter
// Input channel with the binary value and output channel with one digit
// character per beat.
// ----------------------------------------------------------------------------
interface bdec_in_if import bdec_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IN_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bdec_out_if import bdec_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

[hdl/bdec_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdec_front: value intake and shift-and-add-3 conversion
// Accepts one value, converts it to packed BCD one bit per cycle and
// pushes the digits with their significant digit count into the queue.
// ----------------------------------------------------------------------------
module bdec_front import bdec_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdec_in_if.sink   i_in,
    output logic      o_push,
    output t_entry    o_entry,
    input  t_q_stat   i_q_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [CONV_BITS-1:0] r_shift, n_shift;
    t_bcd                 r_bcd,   n_bcd;
    logic [SCNT_W-1:0]    r_cnt,   n_cnt;

    t_bcd  w_adj;
    t_dcnt w_count;
    logic  w_bcd_ok;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // Number of digits up to the most significant nonzero one, at least one.
    always_comb begin
        w_count  = DCNT_W'(1);
        w_bcd_ok = 1'b1;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                w_count = DCNT_W'(i + 1);
            end
            if (r_bcd[4*i +: 4] > 4'd9) begin
                w_bcd_ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_shift = i_in.value[CONV_BITS-1:0];
                    n_bcd   = '0;
                    n_cnt   = SCNT_W'(CONV_BITS);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd   = {w_adj[BCD_BITS-2:0], r_shift[CONV_BITS-1]};
                n_shift = r_shift << 1;
                n_cnt   = r_cnt - SCNT_W'(1);
                if (r_cnt == SCNT_W'(1)) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_push        = (r_state == ST_PUSH) && !i_q_stat.full;
    assign o_entry.bcd   = r_bcd;
    assign o_entry.count = w_count;

    a_bcd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV || r_state == ST_PUSH) |-> w_bcd_ok)
        else $error("front: BCD digit out of range during conversion");

    a_conv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) |-> (r_cnt == '0))
        else $error("front: queue push before all bits were shifted");

endmodule

[hdl/bdec_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdec_fifo: short queue between converter and digit emitter
// Holds converted values so that conversion and emission stall apart.
// ----------------------------------------------------------------------------
module bdec_fifo import bdec_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_q_stat o_stat
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;

    logic w_wr_en;
    logic w_rd_en;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_wr_en      = i_push && !o_stat.full;
    assign w_rd_en      = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_wr_en) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
        end
        if (w_rd_en) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
        end
        if (w_wr_en && !w_rd_en) begin
            n_count = r_count + QCNT_W'(1);
        end else if (w_rd_en && !w_wr_en) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("fifo: occupancy beyond depth");

endmodule

[hdl/bdec_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdec_back: digit character emitter
// Takes one converted value from the queue and sends its significant
// digits as ASCII characters through a registered output stage.
// ----------------------------------------------------------------------------
module bdec_back import bdec_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    bdec_out_if.source o_out
);

    logic                 r_active;
    t_bcd                 r_bcd;
    t_pos                 r_pos;
    logic                 r_valid;
    logic [CHAR_BITS-1:0] r_char;
    logic                 r_last;

    logic       w_slot_free;
    logic       w_emit;
    logic [3:0] w_digit;
    t_dcnt      w_start;

    assign w_slot_free = !r_valid || o_out.ready;
    assign w_emit      = r_active && w_slot_free;
    assign o_pop       = !r_active && !i_q_stat.empty;
    assign w_digit     = r_bcd[4*r_pos +: 4];
    assign w_start     = i_head.count - DCNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (w_emit && r_pos == '0) begin
                r_active <= 1'b0;
            end
            if (w_slot_free) begin
                r_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bcd <= i_head.bcd;
            r_pos <= w_start[POS_W-1:0];
        end else if (w_emit) begin
            r_pos <= r_pos - POS_W'(1);
        end
        if (w_emit) begin
            r_char <= ASCII_ZERO + {{(CHAR_BITS-4){1'b0}}, w_digit};
            r_last <= (r_pos == '0);
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.digit_char = r_char;
    assign o_out.last_digit = r_last;

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_char >= ASCII_ZERO && r_char <= ASCII_NINE))
        else $error("back: emitted character is not a decimal digit");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pos < POS_W'(MAX_DIGITS)))
        else $error("back: digit position beyond the digit buffer");

endmodule

[hdl/binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII characters
// Converts each 32-bit value to its decimal digits, most significant
// first, with leading zeros suppressed and the final digit marked.
// ----------------------------------------------------------------------------
// Usage
//   i_in carries one unsigned value per beat (valid/ready handshake).
//   o_out carries one ASCII digit per beat; last_digit is high on the least
//   significant digit of each value. Zero gives the single character '0'.
//   A value accepted on i_in passes through the shift-and-add-3 conversion
//   in the converter, the push into the queue, the load of the emitter and
//   the registered output stage before its first character shows on o_out.
//   The converter takes a new value only after it has converted the last
//   one and pushed it into the queue; the emitter sends one character per
//   cycle while the receiver holds ready high, so values of up to ten
//   digits keep pace with the converter.
//   Reset (synchronous, active low) empties the queue and drops any value
//   in flight or any character held on o_out.
//   When the receiver holds ready low, the emitter keeps its character,
//   the two-entry queue fills, and then the converter waits with its result
//   and i_in.ready stays low until room frees up.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import bdec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdec_in_if.sink    i_in,
    bdec_out_if.source o_out
);

    // Converter to queue.
    logic    w_push;
    t_entry  w_push_entry;

    // Queue to emitter.
    logic    w_pop;
    t_entry  w_head;
    t_q_stat w_q_stat;

    // Front part: takes a value, runs the bit-serial BCD conversion and
    // pushes the digits into the queue with their count of significant digits.
    bdec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_push   (w_push),
        .o_entry  (w_push_entry),
        .i_q_stat (w_q_stat)
    );

    // Short queue so the converter can start the next value while the
    // emitter is still sending or is held by the receiver.
    bdec_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_stat   (w_q_stat)
    );

    // Back part: walks the significant digits from the top down and sends
    // each one as an ASCII character.
    bdec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule
